>>> hw/rtl/lbps_pkg.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer package
// Request and result types, entry kinds and the constant pattern ROM.
// ----------------------------------------------------------------------------
package lbps_pkg;

    localparam int IDX_W   = 4;
    localparam int DLY_W   = 5;
    localparam int PAT_W   = 2;

    localparam logic [PAT_W-1:0] PAT_COUNT = 2'd3;
    localparam logic [PAT_W-1:0] PAT_NONE  = 2'd3;

    // request opcodes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_DELAY = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DLY_W-1:0]   arg;
    } t_rom_entry;

    typedef struct packed {
        logic               operation;
        logic [PAT_W-1:0]   pattern_sel;
        logic               enable_req;
        logic               repeat_req;
    } t_in_item;

    typedef struct packed {
        logic               led_on;
        logic               running;
        logic               select_accepted;
        logic [PAT_W-1:0]   active_pattern;
    } t_out_item;

    // number of entries in each pattern, end entry included
    function automatic logic [IDX_W:0] pattern_len(input logic [PAT_W-1:0] pat);
        logic [IDX_W:0] len;
        case (pat)
            2'd0:    len = 5'd3;
            2'd1:    len = 5'd5;
            2'd2:    len = 5'd15;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // pattern ROM lookup; unlisted slots read as end entries
    function automatic t_rom_entry rom_entry(input logic [PAT_W-1:0] pat,
                                             input logic [IDX_W-1:0] idx);
        t_rom_entry e;
        e = '{kind: KIND_END, arg: '0};
        case (pat)
            2'd0: begin
                case (idx)
                    4'd0:    e = '{kind: KIND_SET,   arg: 5'd1};
                    4'd1:    e = '{kind: KIND_DELAY, arg: 5'd31};
                    default: e = '{kind: KIND_END,   arg: 5'd0};
                endcase
            end
            2'd1: begin
                case (idx)
                    4'd0:    e = '{kind: KIND_SET,   arg: 5'd1};
                    4'd1:    e = '{kind: KIND_DELAY, arg: 5'd1};
                    4'd2:    e = '{kind: KIND_SET,   arg: 5'd0};
                    4'd3:    e = '{kind: KIND_DELAY, arg: 5'd9};
                    default: e = '{kind: KIND_END,   arg: 5'd0};
                endcase
            end
            2'd2: begin
                case (idx)
                    4'd0, 4'd4, 4'd8:   e = '{kind: KIND_SET,   arg: 5'd1};
                    4'd1, 4'd5, 4'd9:   e = '{kind: KIND_DELAY, arg: 5'd1};
                    4'd2, 4'd6, 4'd10:  e = '{kind: KIND_SET,   arg: 5'd0};
                    4'd3, 4'd7, 4'd11:  e = '{kind: KIND_DELAY, arg: 5'd2};
                    4'd12:              e = '{kind: KIND_SET,   arg: 5'd0};
                    4'd13:              e = '{kind: KIND_DELAY, arg: 5'd18};
                    default:            e = '{kind: KIND_END,   arg: 5'd0};
                endcase
            end
            default: e = '{kind: KIND_END, arg: 5'd0};
        endcase
        return e;
    endfunction

endpackage

>>> hw/rtl/lbps_core.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer core
// Holds the sequencer state and executes one tick or select request per
// cycle in which i_advance is high.
// ----------------------------------------------------------------------------
module lbps_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  lbps_pkg::t_in_item  i_item,
    output lbps_pkg::t_out_item o_result
);
    import lbps_pkg::*;

    logic               r_run;
    logic               r_loop;
    logic [IDX_W-1:0]   r_idx;
    logic [DLY_W-1:0]   r_dly;
    logic [PAT_W-1:0]   r_pat;
    logic               r_led;

    logic               n_run;
    logic               n_loop;
    logic [IDX_W-1:0]   n_idx;
    logic [DLY_W-1:0]   n_dly;
    logic [PAT_W-1:0]   n_pat;
    logic               n_led;
    logic               accepted;

    t_rom_entry         cur_entry;
    t_rom_entry         exec_entry;
    logic [IDX_W-1:0]   base_idx;
    logic [DLY_W-1:0]   base_dly;
    logic [DLY_W-1:0]   dly_inc;

    // entry lookups for the current index and for the wrap target
    assign cur_entry = rom_entry(r_pat, r_idx);

    // next state for tick and select requests
    always_comb begin
        n_run      = r_run;
        n_loop     = r_loop;
        n_idx      = r_idx;
        n_dly      = r_dly;
        n_pat      = r_pat;
        n_led      = r_led;
        accepted   = 1'b0;
        exec_entry = cur_entry;
        base_idx   = r_idx;
        base_dly   = r_dly;
        dly_inc    = '0;
        if (i_item.operation == OP_SELECT) begin
            if (i_item.pattern_sel != r_pat && i_item.pattern_sel != PAT_NONE) begin
                accepted = 1'b1;
                n_run    = i_item.enable_req;
                n_loop   = i_item.repeat_req;
                n_idx    = '0;
                n_dly    = '0;
                n_pat    = i_item.pattern_sel;
            end
        end else if (r_run) begin
            if (r_pat >= PAT_COUNT || {1'b0, r_idx} >= pattern_len(r_pat)) begin
                n_run = 1'b0;
            end else begin
                // end entry wraps to entry zero or stops the sequencer
                if (cur_entry.kind == KIND_END) begin
                    if (r_loop) begin
                        base_idx   = '0;
                        base_dly   = '0;
                        exec_entry = rom_entry(r_pat, '0);
                    end else begin
                        n_run = 1'b0;
                    end
                end
                if (exec_entry.kind != KIND_DELAY) begin
                    n_led = (exec_entry.kind == KIND_SET) ? exec_entry.arg[0] : 1'b0;
                    n_dly = '0;
                    n_idx = base_idx + 1'b1;
                end else begin
                    dly_inc = base_dly + 1'b1;
                    if (dly_inc >= exec_entry.arg) begin
                        n_dly = '0;
                        n_idx = base_idx + 1'b1;
                    end else begin
                        n_dly = dly_inc;
                        n_idx = base_idx;
                    end
                end
            end
        end
    end

    // result of this request
    always_comb begin
        o_result.led_on          = n_led;
        o_result.running         = n_run;
        o_result.select_accepted = accepted;
        o_result.active_pattern  = n_pat;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_loop <= 1'b0;
            r_idx  <= '0;
            r_dly  <= '0;
            r_pat  <= PAT_NONE;
            r_led  <= 1'b0;
        end else if (i_advance) begin
            r_run  <= n_run;
            r_loop <= n_loop;
            r_idx  <= n_idx;
            r_dly  <= n_dly;
            r_pat  <= n_pat;
            r_led  <= n_led;
        end
    end

endmodule

>>> hw/rtl/led_blink_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer
// Steps an LED through one of three fixed blink patterns, one tick at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_in_item): a tick request
//   (operation 0) executes one pattern step; a select request (operation 1)
//   loads a pattern with its enable and repeat flags, and is refused when it
//   names the loaded pattern or pattern 3.
//   Result channel (o_out_valid / i_out_stall / o_out_item): exactly one
//   result per request, in order, with LED level, running flag, whether the
//   select was taken, and the loaded pattern (3 = none since reset).
//   Path: a request goes into the input register, is executed by the core
//   once the result queue has room or is being read, and lands in the
//   two-entry result queue, from which the receiver takes it.
//   Throughput: one request per cycle while results drain; the core updates
//   all sequencer state once per request.
//   Stall: when the result queue is full and the receiver stalls, the input
//   register holds and o_in_stall rises; nothing is dropped.
//   Reset: synchronous, active low; the LED is off, the sequencer stopped,
//   no pattern is loaded and both channels are empty.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lbps_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lbps_pkg::t_out_item o_out_item
);
    import lbps_pkg::*;

    logic               r_in_valid;
    t_in_item           r_in_item;
    t_out_item          r_fifo [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;

    logic               pop;
    logic               advance;
    logic               take;
    t_out_item          core_result;

    // queue handshake
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_item  = r_fifo[r_rd_ptr];
    assign pop         = o_out_valid && !i_out_stall;
    assign advance     = r_in_valid && ((r_count != 2'd2) || pop);
    assign o_in_stall  = r_in_valid && !advance;
    assign take        = i_in_valid && !o_in_stall;

    // sequencer core
    lbps_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (core_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_item <= i_in_item;
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (advance) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({advance, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fifo[r_wr_ptr] <= core_result;
        end
    end

endmodule

>>> hw/rtl/lbps_checker.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer checker
// Port-level assertions on the request and result channels, bound to the
// top level.
// ----------------------------------------------------------------------------
module lbps_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  lbps_pkg::t_in_item  i_in_item,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  lbps_pkg::t_out_item o_out_item
);
    import lbps_pkg::*;

    // no result right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result shown right after reset");

    // a stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled request changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // a taken select always leaves a real pattern loaded
    a_select_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.select_accepted |->
            o_out_item.active_pattern != PAT_NONE)
        else $error("select taken with no pattern loaded");

    // running needs a loaded pattern
    a_run_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.running |-> o_out_item.active_pattern != PAT_NONE)
        else $error("running with no pattern loaded");

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
